/* design/uer_pkg.sv */
// Shared types and constants for the ultrasonic echo ranger.
// Used by every module of the block; depends on nothing.
package uer_pkg;

    // Item operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH = 2'd2;
    localparam int CFG_DATA_W = 16;

    localparam int TIMEOUT_W = 16;
    localparam int TRIG_W    = 8;
    localparam int DIST_W    = 11;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd30000;
    localparam logic [TRIG_W-1:0]    TRIG_LOW_RST  = 8'd4;
    localparam logic [TRIG_W-1:0]    TRIG_HIGH_RST = 8'd10;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // Distance arithmetic: d = floor((c*343 + 10000) / 20000), saturating at 2047.
    // Counts at or above SAT_COUNT saturate. Below that, n = c*343 + 10000 fits
    // 26 bits, and n/20000 = (n >> 5) / 625, done as a multiply by the
    // reciprocal RECIP_625 = ceil(2^30 / 625), which is exact for n >> 5 < 2^21.
    localparam logic [31:0] SAT_COUNT  = 32'd119388;
    localparam int          SCALED_W   = 26;
    localparam int          QUOT_W     = 21;
    localparam int          PROD_W     = 42;
    localparam int          RECIP_SH   = 30;
    localparam logic [SCALED_W-1:0] SOUND_MUL  = 26'd343;
    localparam logic [SCALED_W-1:0] ROUND_ADD  = 26'd10000;
    localparam logic [QUOT_W-1:0]   RECIP_625  = 21'd1717987;
    localparam logic [DIST_W-1:0]   DIST_SAT   = 11'd2047;

    typedef struct packed {
        logic is_start;
        logic sensor_sel;
        logic echo_front;
        logic echo_back;
    } cmd_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout;
        logic [TRIG_W-1:0]    trig_low;
        logic [TRIG_W-1:0]    trig_high;
    } cfg_t;

    typedef struct packed {
        logic trig_front;
        logic trig_back;
        logic busy;
        logic done;
        logic timed_out;
    } flags_t;

endpackage

/* design/uer_front.sv */
// Front stage of the ranger: registers and classifies incoming items.
// Depends on uer_pkg.
module uer_front
    import uer_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic op,
    input  logic sensor_sel,
    input  logic echo_front,
    input  logic echo_back,
    output logic cmd_valid,
    input  logic cmd_ready,
    output cmd_t cmd
);

    logic valid_reg;
    cmd_t cmd_reg;
    logic take;

    assign take      = !valid_reg || cmd_ready;
    assign in_stall  = !take;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_valid)
        begin
            cmd_reg.is_start   <= (op == OP_START);
            cmd_reg.sensor_sel <= sensor_sel;
            cmd_reg.echo_front <= echo_front;
            cmd_reg.echo_back  <= echo_back;
        end
    end

endmodule

/* design/uer_queue.sv */
// Short command queue between the front and back stages.
// Depends on uer_pkg.
module uer_queue
    import uer_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* design/uer_back.sv */
// Back stage: the measurement sequencer, one command per cycle unless stalled.
// Depends on uer_pkg.
module uer_back
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_t                  cmd,
    input  cfg_t                  cfg,
    output logic                  res_valid,
    input  logic                  res_ready,
    output flags_t                res_flags,
    output logic [COUNT_BITS-1:0] res_count
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TRIG_LOW,
        PH_TRIG_HIGH,
        PH_WAIT_RISE,
        PH_MEASURE
    } phase_t;

    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  sensor_reg;
    logic                  sensor_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic [31:0]           count_ext;
    logic [31:0]           inc_ext;
    logic [TRIG_W-1:0]     high_len;
    logic                  at_limit;
    logic                  echo;
    logic                  fire;
    logic                  done;
    logic                  timed_out;
    logic                  trig;

    assign fire      = cmd_valid && res_ready;
    assign cmd_ready = res_ready;
    assign res_valid = cmd_valid;

    assign count_inc = count_reg + 1'b1;
    assign count_ext = 32'(count_reg);
    assign inc_ext   = 32'(count_inc);
    assign high_len  = (cfg.trig_high == '0) ? TRIG_W'(1) : cfg.trig_high;
    // Limit is the timeout capped at the largest count the counter can hold.
    assign at_limit  = (count_ext >= 32'(cfg.timeout)) || (count_ext >= COUNT_MAX);
    assign echo      = sensor_reg ? cmd.echo_front : cmd.echo_back;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        sensor_next = sensor_reg;
        done        = 1'b0;
        timed_out   = 1'b0;
        if (cmd.is_start)
        begin
            if (phase_reg == PH_IDLE)
            begin
                sensor_next = cmd.sensor_sel;
                count_next  = '0;
                phase_next  = (cfg.trig_low == '0) ? PH_TRIG_HIGH : PH_TRIG_LOW;
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_TRIG_LOW:
                begin
                    count_next = count_inc;
                    if (inc_ext >= 32'(cfg.trig_low))
                    begin
                        count_next = '0;
                        phase_next = PH_TRIG_HIGH;
                    end
                end
                PH_TRIG_HIGH:
                begin
                    count_next = count_inc;
                    if (inc_ext >= 32'(high_len))
                    begin
                        count_next = '0;
                        phase_next = PH_WAIT_RISE;
                    end
                end
                PH_WAIT_RISE:
                begin
                    if (echo)
                    begin
                        count_next = COUNT_BITS'(1);
                        phase_next = PH_MEASURE;
                    end
                    else if (at_limit)
                    begin
                        done      = 1'b1;
                        timed_out = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                PH_MEASURE:
                begin
                    if (!echo)
                    begin
                        done = 1'b1;
                    end
                    else if (at_limit)
                    begin
                        done      = 1'b1;
                        timed_out = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
            if (done)
            begin
                phase_next = PH_IDLE;
                count_next = '0;
            end
        end
    end

    // The count is passed on before it is cleared, so the distance stage
    // sees the pulse length of the finished measurement.
    assign trig                 = (phase_next == PH_TRIG_HIGH);
    assign res_flags.trig_front = sensor_next && trig;
    assign res_flags.trig_back  = !sensor_next && trig;
    assign res_flags.busy       = (phase_next != PH_IDLE);
    assign res_flags.done       = done;
    assign res_flags.timed_out  = timed_out;
    assign res_count            = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            sensor_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            sensor_reg <= sensor_next;
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && timed_out |-> done)
        else $error("timeout flagged without a finished measurement");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && done |-> (phase_reg == PH_WAIT_RISE || phase_reg == PH_MEASURE))
        else $error("measurement finished outside a waiting phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd.is_start && phase_reg != PH_IDLE |=> $stable(sensor_reg))
        else $error("start while busy changed the chosen sensor");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> count_reg == '0)
        else $error("tick count not cleared in idle");
`endif

endmodule

/* design/uer_dist.sv */
// Result pipeline of the ranger: distance arithmetic and the output register.
// Depends on uer_pkg.
module uer_dist
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_valid,
    output logic                  res_ready,
    input  flags_t                res_flags,
    input  logic [COUNT_BITS-1:0] res_count,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  trig_front,
    output logic                  trig_back,
    output logic                  busy_res,
    output logic                  done_res,
    output logic                  timed_out,
    output logic [DIST_W-1:0]     distance_cm
);

    // Stage 0: sequencer result
    logic                  s0_valid_reg;
    flags_t                s0_flags_reg;
    logic [COUNT_BITS-1:0] s0_count_reg;
    // Stage 1: scaled count
    logic                  s1_valid_reg;
    flags_t                s1_flags_reg;
    logic                  s1_sat_reg;
    logic [SCALED_W-1:0]   s1_scaled_reg;
    // Stage 2: reciprocal product
    logic                  s2_valid_reg;
    flags_t                s2_flags_reg;
    logic                  s2_sat_reg;
    logic [PROD_W-1:0]     s2_prod_reg;
    // Output register
    logic                  out_valid_reg;
    flags_t                out_flags_reg;
    logic [DIST_W-1:0]     out_dist_reg;

    logic                  out_take;
    logic                  s2_take;
    logic                  s1_take;
    logic                  s0_take;
    logic [31:0]           count_ext;
    logic [SCALED_W-1:0]   scaled_next;
    logic [DIST_W-1:0]     dist_next;

    assign out_take  = !out_valid_reg || !out_stall;
    assign s2_take   = !s2_valid_reg || out_take;
    assign s1_take   = !s1_valid_reg || s2_take;
    assign s0_take   = !s0_valid_reg || s1_take;
    assign res_ready = s0_take;

    assign count_ext   = 32'(s0_count_reg);
    assign scaled_next = SCALED_W'(count_ext[16:0]) * SOUND_MUL + ROUND_ADD;

    always_comb
    begin
        if (!s2_flags_reg.done || s2_flags_reg.timed_out)
        begin
            dist_next = '0;
        end
        else if (s2_sat_reg)
        begin
            dist_next = DIST_SAT;
        end
        else
        begin
            dist_next = s2_prod_reg[RECIP_SH +: DIST_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_take)
            begin
                s0_valid_reg <= res_valid;
            end
            if (s1_take)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_take)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_take)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_take && res_valid)
        begin
            s0_flags_reg <= res_flags;
            s0_count_reg <= res_count;
        end
        if (s1_take && s0_valid_reg)
        begin
            s1_flags_reg  <= s0_flags_reg;
            s1_sat_reg    <= (count_ext >= SAT_COUNT);
            s1_scaled_reg <= scaled_next;
        end
        if (s2_take && s1_valid_reg)
        begin
            s2_flags_reg <= s1_flags_reg;
            s2_sat_reg   <= s1_sat_reg;
            s2_prod_reg  <= PROD_W'(s1_scaled_reg[SCALED_W-1:5]) * PROD_W'(RECIP_625);
        end
        if (out_take && s2_valid_reg)
        begin
            out_flags_reg <= s2_flags_reg;
            out_dist_reg  <= dist_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign trig_front  = out_flags_reg.trig_front;
    assign trig_back   = out_flags_reg.trig_back;
    assign busy_res    = out_flags_reg.busy;
    assign done_res    = out_flags_reg.done;
    assign timed_out   = out_flags_reg.timed_out;
    assign distance_cm = out_dist_reg;

endmodule

/* design/ultrasonic_echo_ranger.sv */
// Ultrasonic echo ranger top level: front stage, command queue, sequencer, result pipeline.
// Items pass the front register, queue, sequencer, stages 0 to 2 and output register.
// Throughput: one item per cycle while out_stall stays low, set by the back stage sequencer.
// Reset (rst_n, asynchronous, active low) empties all stages and the queue, puts the
// sequencer in idle with the back sensor chosen, and restores the register defaults.
// Depends on uer_pkg, uer_front, uer_queue, uer_back and uer_dist.
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input item channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic                  sensor_sel,
    input  logic                  echo_front,
    input  logic                  echo_back,
    // Result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  trig_front,
    output logic                  trig_back,
    output logic                  busy_res,
    output logic                  done_res,
    output logic                  timed_out,
    output logic [DIST_W-1:0]     distance_cm,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // The configuration registers. Writes are always taken; an index beyond
    // the register list completes its transfer and changes nothing. The user must
    // write only while the block is idle, which the block does not enforce.
    cfg_t cfg_reg;

    // Front to queue, and queue to sequencer
    logic   front_valid;
    logic   front_ready;
    cmd_t   front_cmd;
    logic   q_valid;
    logic   q_ready;
    cmd_t   q_cmd;

    // Sequencer to result pipeline
    logic                  res_valid;
    logic                  res_ready;
    flags_t                res_flags;
    logic [COUNT_BITS-1:0] res_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout   <= TIMEOUT_RST;
            cfg_reg.trig_low  <= TRIG_LOW_RST;
            cfg_reg.trig_high <= TRIG_HIGH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TIMEOUT:
                begin
                    cfg_reg.timeout <= cfg_data[TIMEOUT_W-1:0];
                end
                CFG_TRIG_LOW:
                begin
                    cfg_reg.trig_low <= cfg_data[TRIG_W-1:0];
                end
                CFG_TRIG_HIGH:
                begin
                    cfg_reg.trig_high <= cfg_data[TRIG_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // The front stage registers each item and marks it as a tick or a start.
    uer_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .sensor_sel (sensor_sel),
        .echo_front (echo_front),
        .echo_back  (echo_back),
        .cmd_valid  (front_valid),
        .cmd_ready  (front_ready),
        .cmd        (front_cmd)
    );

    // The queue's ready comes from its own fill count, so a stall on the
    // result side never reaches the input channel in the same cycle.
    uer_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    // The sequencer steps the trigger, echo-wait and measuring phases, one
    // command per cycle unless stalled, and hands the flags and pulse length onwards.
    uer_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_flags (res_flags),
        .res_count (res_count)
    );

    // The result pipeline turns the pulse length into centimetres with a
    // multiply, then a reciprocal multiply, and holds the finished result
    // in the output register until the transfer completes.
    uer_dist #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_flags   (res_flags),
        .res_count   (res_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .trig_front  (trig_front),
        .trig_back   (trig_back),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .timed_out   (timed_out),
        .distance_cm (distance_cm)
    );

endmodule
